// ===== hdl/rhpq_pkg.sv =====
// package: controller states, command and status bundles, operation codes
`timescale 1ns / 1ps
`default_nettype none
package rhpq_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_ALLOC,
      ST_APP_RD,
      ST_APP_W1,
      ST_APP_W2,
      ST_POP_TAIL,
      ST_POP_SLOT,
      ST_POP_W1,
      ST_POP_W2,
      ST_SCAN_START,
      ST_SCAN_HEAD,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_REF_START,
      ST_REF_RD,
      ST_REF_BKT,
      ST_REF_NEXT,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load_in;
      logic dispatch;
      logic alloc;
      logic app_rd;
      logic app_w1;
      logic app_w2;
      logic pop_tail;
      logic pop_slot;
      logic pop_w1;
      logic pop_w2;
      logic scan_start;
      logic scan_head;
      logic scan_rd;
      logic scan_cmp;
      logic ref_start;
      logic ref_rd;
      logic ref_bkt;
      logic ref_next;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_push;
      logic full;
      logic ne0;
      logic any_ne;
      logic tail_nil;
      logic scan_end;
      logic ref_end;
      logic out_free;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// ===== hdl/rhpq_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module rhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hdl/rhpq_ctrl.sv =====
// controller state machine sequencing push, pop, scan and re-file
`timescale 1ns / 1ps
`default_nettype none
module rhpq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire rhpq_pkg::ctrl_stat_type stat,
   output rhpq_pkg::ctrl_cmd_type      cmd
);
   import rhpq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (stat.is_push) begin
               state_in = stat.full ? ST_FIN : ST_ALLOC;
            end else if (stat.ne0) begin
               state_in = ST_POP_TAIL;
            end else if (stat.any_ne) begin
               state_in = ST_SCAN_START;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ALLOC:      state_in = ST_APP_RD;
         ST_APP_RD:     state_in = ST_APP_W1;
         ST_APP_W1: begin
            if (!stat.tail_nil) state_in = ST_APP_W2;
            else state_in = stat.is_push ? ST_FIN : ST_REF_NEXT;
         end
         ST_APP_W2:     state_in = stat.is_push ? ST_FIN : ST_REF_NEXT;
         ST_POP_TAIL:   state_in = ST_POP_SLOT;
         ST_POP_SLOT:   state_in = ST_POP_W1;
         ST_POP_W1:     state_in = ST_POP_W2;
         ST_POP_W2:     state_in = ST_FIN;
         ST_SCAN_START: state_in = ST_SCAN_HEAD;
         ST_SCAN_HEAD:  state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = ST_SCAN_CMP;
         ST_SCAN_CMP:   state_in = stat.scan_end ? ST_REF_START : ST_SCAN_RD;
         ST_REF_START:  state_in = ST_REF_RD;
         ST_REF_RD:     state_in = ST_REF_BKT;
         ST_REF_BKT:    state_in = ST_APP_RD;
         ST_REF_NEXT:   state_in = stat.ref_end ? ST_POP_TAIL : ST_REF_RD;
         ST_FIN: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.load_in = req_tvalid;
         end
         ST_DISPATCH:   cmd.dispatch   = 1'b1;
         ST_ALLOC:      cmd.alloc      = 1'b1;
         ST_APP_RD:     cmd.app_rd     = 1'b1;
         ST_APP_W1:     cmd.app_w1     = 1'b1;
         ST_APP_W2:     cmd.app_w2     = 1'b1;
         ST_POP_TAIL:   cmd.pop_tail   = 1'b1;
         ST_POP_SLOT:   cmd.pop_slot   = 1'b1;
         ST_POP_W1:     cmd.pop_w1     = 1'b1;
         ST_POP_W2:     cmd.pop_w2     = 1'b1;
         ST_SCAN_START: cmd.scan_start = 1'b1;
         ST_SCAN_HEAD:  cmd.scan_head  = 1'b1;
         ST_SCAN_RD:    cmd.scan_rd    = 1'b1;
         ST_SCAN_CMP:   cmd.scan_cmp   = 1'b1;
         ST_REF_START:  cmd.ref_start  = 1'b1;
         ST_REF_RD:     cmd.ref_rd     = 1'b1;
         ST_REF_BKT:    cmd.ref_bkt    = 1'b1;
         ST_REF_NEXT:   cmd.ref_next   = 1'b1;
         ST_FIN:        cmd.finish     = 1'b1;
         default:       cmd = '0;
      endcase
   end
endmodule
`default_nettype wire

// ===== hdl/rhpq_dp.sv =====
// datapath: slot and bucket memories, free list, result and output registers
`timescale 1ns / 1ps
`default_nettype none
module rhpq_dp #(
   parameter int KEY_BITS     = 32,
   parameter int BUCKET_COUNT = 33,
   parameter int CAPACITY     = 1024,
   parameter int VALUE_BITS   = 16,
   localparam int IW = $clog2(CAPACITY + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rhpq_pkg::ctrl_cmd_type  cmd,
   output rhpq_pkg::ctrl_stat_type      stat,
   input  wire logic                    in_cmd,
   input  wire logic [KEY_BITS-1:0]     in_key,
   input  wire logic [VALUE_BITS-1:0]   in_value,
   input  wire logic                    rsp_tready,
   output logic                         rsp_tvalid,
   output logic [KEY_BITS-1:0]          out_key,
   output logic [VALUE_BITS-1:0]        out_value,
   output logic                         out_valid,
   output logic                         push_dropped,
   output logic                         is_empty,
   output logic [IW-1:0]                entry_count
);
   import rhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int BW = $clog2(BUCKET_COUNT);
   localparam int LW = $clog2(KEY_BITS + 1);
   localparam logic [IW-1:0] NIL = IW'(CAPACITY);

   function automatic logic [BW-1:0] bucket_of(input logic [KEY_BITS-1:0] k,
                                                input logic [KEY_BITS-1:0] base);
      logic [KEY_BITS-1:0] d;
      logic [LW-1:0]       len;
      d = k ^ base;
      len = '0;
      for (int j = 0; j < KEY_BITS; j++) begin
         if (d[j]) len = LW'(j + 1);
      end
      if (int'(len) > BUCKET_COUNT - 1) return BW'(BUCKET_COUNT - 1);
      return BW'(len);
   endfunction

   // control and payload registers
   logic                  cmd_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [IW-1:0]         cur_ff, nx_ff, tail_ff, head_sv_ff, rec_head_ff, fresh_ff;
   logic [IW-1:0]         count_ff;
   logic [BW-1:0]         bkt_ff;
   logic                  alloc_rec_ff;
   logic [KEY_BITS-1:0]   min_ff, last_ff;
   logic [BUCKET_COUNT-1:0] ne_ff;
   logic [KEY_BITS-1:0]   res_key_ff;
   logic [VALUE_BITS-1:0] res_value_ff;
   logic                  res_valid_ff, res_drop_ff;
   logic                  rsp_valid_ff;
   logic [KEY_BITS-1:0]   rsp_key_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_ok_ff, rsp_drop_ff, rsp_empty_ff;
   logic [IW-1:0]         rsp_count_ff;

   // memory ports
   logic                  key_we, val_we, next_we, prev_we, head_we, tail_we;
   logic                  key_re, val_re, next_re, prev_re, head_re, tail_re;
   logic [AW-1:0]         key_wa, key_ra, next_wa, next_ra, prev_wa, prev_ra;
   logic [BW-1:0]         head_wa, head_ra, tail_wa, tail_ra;
   logic [KEY_BITS-1:0]   key_rd;
   logic [VALUE_BITS-1:0] val_rd;
   logic [IW-1:0]         next_wd, next_rd, prev_wd, prev_rd, head_wd, head_rd;
   logic [IW-1:0]         tail_wd, tail_rd;

   logic [IW-1:0]         alloc_slot, app_t;
   logic [BW-1:0]         first_bkt;
   logic                  out_free;

   assign alloc_slot = (rec_head_ff != NIL) ? rec_head_ff : fresh_ff;
   assign app_t      = ne_ff[bkt_ff] ? tail_rd : NIL;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      first_bkt = '0;
      for (int j = BUCKET_COUNT - 1; j >= 1; j--) begin
         if (ne_ff[j]) first_bkt = BW'(j);
      end
   end

   assign stat.is_push  = (cmd_ff == CMD_PUSH);
   assign stat.full     = (count_ff >= NIL);
   assign stat.ne0      = ne_ff[0];
   assign stat.any_ne   = |ne_ff;
   assign stat.tail_nil = !ne_ff[bkt_ff];
   assign stat.scan_end = (next_rd == NIL);
   assign stat.ref_end  = (nx_ff == NIL);
   assign stat.out_free = out_free;

   always_comb begin
      key_we = 1'b0; val_we = 1'b0; next_we = 1'b0;
      prev_we = 1'b0; head_we = 1'b0; tail_we = 1'b0;
      key_re = 1'b0; val_re = 1'b0; next_re = 1'b0;
      prev_re = 1'b0; head_re = 1'b0; tail_re = 1'b0;
      key_wa  = alloc_slot[AW-1:0];
      key_ra  = cur_ff[AW-1:0];
      next_wa = cur_ff[AW-1:0];
      next_wd = NIL;
      next_ra = cur_ff[AW-1:0];
      prev_wa = cur_ff[AW-1:0];
      prev_wd = app_t;
      prev_ra = tail_rd[AW-1:0];
      head_wa = bkt_ff;
      head_wd = cur_ff;
      head_ra = first_bkt;
      tail_wa = bkt_ff;
      tail_wd = cur_ff;
      tail_ra = bkt_ff;
      if (cmd.alloc) begin
         key_we  = 1'b1;
         val_we  = 1'b1;
         next_re = 1'b1;
         next_ra = rec_head_ff[AW-1:0];
      end
      if (cmd.app_rd) tail_re = 1'b1;
      if (cmd.app_w1) begin
         next_we = 1'b1;
         prev_we = 1'b1;
         tail_we = 1'b1;
         head_we = !ne_ff[bkt_ff];
      end
      if (cmd.app_w2) begin
         next_we = 1'b1;
         next_wa = tail_ff[AW-1:0];
         next_wd = cur_ff;
      end
      if (cmd.pop_tail) begin
         tail_re = 1'b1;
         tail_ra = '0;
      end
      if (cmd.pop_slot) begin
         prev_re = 1'b1;
         key_re  = 1'b1;
         val_re  = 1'b1;
         key_ra  = tail_rd[AW-1:0];
      end
      if (cmd.pop_w1) begin
         tail_we = 1'b1;
         tail_wa = '0;
         tail_wd = prev_rd;
         next_we = (prev_rd != NIL);
         next_wa = prev_rd[AW-1:0];
         next_wd = NIL;
      end
      if (cmd.pop_w2) begin
         next_we = 1'b1;
         next_wd = rec_head_ff;
      end
      if (cmd.scan_start) head_re = 1'b1;
      if (cmd.scan_rd || cmd.ref_rd) begin
         key_re  = 1'b1;
         next_re = 1'b1;
      end
   end

   rhpq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_ff),
      .rd_en(key_re), .rd_addr(key_ra), .rd_data(key_rd));
   rhpq_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value (
      .clock(clock), .wr_en(val_we), .wr_addr(key_wa), .wr_data(value_ff),
      .rd_en(val_re), .rd_addr(key_ra), .rd_data(val_rd));
   rhpq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_en(next_re), .rd_addr(next_ra), .rd_data(next_rd));
   rhpq_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_en(prev_re), .rd_addr(prev_ra), .rd_data(prev_rd));
   rhpq_ram #(.WIDTH(IW), .DEPTH(BUCKET_COUNT)) u_head (
      .clock(clock), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
      .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd));
   rhpq_ram #(.WIDTH(IW), .DEPTH(BUCKET_COUNT)) u_tail (
      .clock(clock), .wr_en(tail_we), .wr_addr(tail_wa), .wr_data(tail_wd),
      .rd_en(tail_re), .rd_addr(tail_ra), .rd_data(tail_rd));

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         cmd_ff   <= in_cmd;
         key_ff   <= in_key;
         value_ff <= in_value;
      end
      if (cmd.alloc) begin
         cur_ff       <= alloc_slot;
         bkt_ff       <= bucket_of(key_ff, last_ff);
         alloc_rec_ff <= (rec_head_ff != NIL);
      end
      if (cmd.app_w1) tail_ff <= app_t;
      if (cmd.pop_slot) cur_ff <= tail_rd;
      if (cmd.scan_start) bkt_ff <= first_bkt;
      if (cmd.scan_head) begin
         cur_ff     <= head_rd;
         head_sv_ff <= head_rd;
         min_ff     <= '1;
      end
      if (cmd.scan_cmp) begin
         if (key_rd < min_ff) min_ff <= key_rd;
         cur_ff <= next_rd;
      end
      if (cmd.ref_start) cur_ff <= head_sv_ff;
      if (cmd.ref_bkt) begin
         nx_ff  <= next_rd;
         bkt_ff <= bucket_of(key_rd, last_ff);
      end
      if (cmd.ref_next) cur_ff <= nx_ff;
      if (cmd.dispatch) begin
         res_key_ff   <= '0;
         res_value_ff <= '0;
         res_valid_ff <= 1'b0;
         res_drop_ff  <= (cmd_ff == CMD_PUSH) && (count_ff >= NIL);
      end
      if (cmd.pop_w1) begin
         res_key_ff   <= key_rd;
         res_value_ff <= val_rd;
         res_valid_ff <= 1'b1;
      end
      if (cmd.finish && out_free) begin
         rsp_key_ff   <= res_key_ff;
         rsp_value_ff <= res_value_ff;
         rsp_ok_ff    <= res_valid_ff;
         rsp_drop_ff  <= res_drop_ff;
         rsp_empty_ff <= (count_ff == '0);
         rsp_count_ff <= count_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff        <= '0;
         count_ff     <= '0;
         last_ff      <= '0;
         rec_head_ff  <= NIL;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.alloc) begin
            count_ff <= count_ff + IW'(1);
            if (rec_head_ff == NIL) fresh_ff <= fresh_ff + IW'(1);
         end
         if (cmd.app_rd && (cmd_ff == CMD_PUSH) && alloc_rec_ff) rec_head_ff <= next_rd;
         if (cmd.app_w1) ne_ff[bkt_ff] <= 1'b1;
         if (cmd.ref_start) begin
            last_ff       <= min_ff;
            ne_ff[bkt_ff] <= 1'b0;
         end
         if (cmd.pop_w1) begin
            if (prev_rd == NIL) ne_ff[0] <= 1'b0;
            last_ff  <= key_rd;
            count_ff <= count_ff - IW'(1);
         end
         if (cmd.pop_w2) rec_head_ff <= cur_ff;
         if (cmd.finish && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign out_key      = rsp_key_ff;
   assign out_value    = rsp_value_ff;
   assign out_valid    = rsp_ok_ff;
   assign push_dropped = rsp_drop_ff;
   assign is_empty     = rsp_empty_ff;
   assign entry_count  = rsp_count_ff;
endmodule
`default_nettype wire

// ===== hdl/radix_heap_priority_queue_top.sv =====
// top level: monotone radix heap priority queue
//
//  channel   dir  handshake              contents
//  req_      in   req_tvalid/req_tready  tuser cmd, tdata key and value
//  rsp_      out  rsp_tvalid/rsp_tready  tdata one result per transaction
//
// push: allocate and append to the key's bucket; pop: unlink the tail of bucket 0; empty pop or
// full push: no memory access; with bucket 0 empty, a pop first scans the lowest non-empty
// bucket for its minimum, then re-files each entry via the slot memories' single read port
// reset is synchronous; no clearing pass, the free list fills from a fresh-slot count
// one transaction at a time; a result waits in the output register while the next is taken
`timescale 1ns / 1ps
`default_nettype none
module radix_heap_priority_queue_top #(
   parameter int KEY_BITS     = 32,
   parameter int BUCKET_COUNT = 33,
   parameter int CAPACITY     = 1024,
   parameter int VALUE_BITS   = 16,
   localparam int IW    = $clog2(CAPACITY + 1),
   localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int OUT_W = ((KEY_BITS + VALUE_BITS + 3 + IW + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [IN_W-1:0]  req_tdata,  // key, value
   input  wire logic             req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [OUT_W-1:0]      rsp_tdata   // out_key, out_value, out_valid, push_dropped,
                                             // is_empty, entry_count
);
   import rhpq_pkg::*;

   ctrl_cmd_type          cmd;
   ctrl_stat_type         stat;
   logic [KEY_BITS-1:0]   out_key;
   logic [VALUE_BITS-1:0] out_value;
   logic                  out_valid, push_dropped, is_empty;
   logic [IW-1:0]         entry_count;

   rhpq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .stat(stat), .cmd(cmd));

   rhpq_dp #(
      .KEY_BITS(KEY_BITS), .BUCKET_COUNT(BUCKET_COUNT),
      .CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .in_cmd(req_tuser),
      .in_key(req_tdata[KEY_BITS-1:0]),
      .in_value(req_tdata[KEY_BITS+VALUE_BITS-1:KEY_BITS]),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .out_key(out_key), .out_value(out_value), .out_valid(out_valid),
      .push_dropped(push_dropped), .is_empty(is_empty), .entry_count(entry_count));

   assign rsp_tdata = OUT_W'({entry_count, is_empty, push_dropped, out_valid,
                              out_value, out_key});

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_valid && push_dropped))
      else $error("pop result and dropped push flagged together");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (is_empty == (entry_count == '0)))
      else $error("empty flag disagrees with entry count");

   a_no_entry_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !out_valid) |-> (out_key == '0 && out_value == '0))
      else $error("payload without a popped entry");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("transaction taken while busy");
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the radix heap priority queue: queue-fed driver, predictor and checking monitor
`timescale 1ns / 1ps
module tb;
   import rhpq_pkg::*;

   localparam int SLOTS   = 1024;
   localparam int BUCKETS = 33;
   localparam int NIL     = SLOTS;
   localparam int LIMIT   = 3000000;

   typedef struct {
      logic        cmd;
      logic [31:0] key;
      logic [15:0] value;
   } heap_op_type;

   typedef struct {
      logic [31:0] key;
      logic [15:0] value;
      logic        valid;
      logic        dropped;
      logic        empty;
      logic [10:0] count;
   } heap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   radix_heap_priority_queue_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   heap_op_type     pending_ops[$];
   heap_result_type expected_results[$];
   heap_op_type     cur_op;
   int              failures = 0;
   int              cycles = 0;

   // predictor state
   logic [31:0] p_key[SLOTS];
   logic [15:0] p_value[SLOTS];
   int          p_next[SLOTS];
   int          p_prev[SLOTS];
   int          p_head[BUCKETS];
   int          p_tail[BUCKETS];
   int          p_free;
   logic [31:0] p_last;
   int          p_held;

   function automatic int bucket_index(logic [31:0] k);
      logic [31:0] d;
      int len;
      d = k ^ p_last;
      len = 0;
      for (int b = 0; b < 32; b++) begin
         if (d[b]) len = b + 1;
      end
      return (len > BUCKETS - 1) ? BUCKETS - 1 : len;
   endfunction

   function automatic void link_tail(int b, int s);
      int t;
      t = p_tail[b];
      p_next[s] = NIL;
      p_prev[s] = t;
      if (t == NIL) p_head[b] = s;
      else p_next[t] = s;
      p_tail[b] = s;
   endfunction

   function automatic void heap_predict(heap_op_type op);
      heap_result_type r;
      int s, b, i, nx;
      logic [31:0] mn;
      r = '{default: '0};
      if (op.cmd == CMD_PUSH) begin
         if (p_held >= SLOTS || p_free == NIL) begin
            r.dropped = 1'b1;
         end else begin
            s = p_free;
            p_free = p_next[s];
            p_key[s] = op.key;
            p_value[s] = op.value;
            link_tail(bucket_index(op.key), s);
            p_held++;
         end
      end else begin
         if (p_head[0] == NIL) begin
            b = 1;
            while (b < BUCKETS && p_head[b] == NIL) b++;
            if (b < BUCKETS) begin
               mn = '1;
               for (i = p_head[b]; i != NIL; i = p_next[i]) begin
                  if (p_key[i] < mn) mn = p_key[i];
               end
               p_last = mn;
               i = p_head[b];
               p_head[b] = NIL;
               p_tail[b] = NIL;
               while (i != NIL) begin
                  nx = p_next[i];
                  link_tail(bucket_index(p_key[i]), i);
                  i = nx;
               end
            end
         end
         if (p_head[0] != NIL) begin
            s = p_tail[0];
            p_tail[0] = p_prev[s];
            if (p_prev[s] == NIL) p_head[0] = NIL;
            else p_next[p_prev[s]] = NIL;
            r.key = p_key[s];
            r.value = p_value[s];
            r.valid = 1'b1;
            p_last = p_key[s];
            p_next[s] = p_free;
            p_free = s;
            p_held--;
         end
      end
      r.empty = (p_held == 0);
      r.count = p_held[10:0];
      expected_results = {expected_results, r};
   endfunction

   // driver
   int  send_wait = 0;
   bit  send_quiet = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 299) == 0) send_quiet = !send_quiet;
         if (req_tvalid && req_tready) begin
            heap_predict(cur_op);
            send_wait = send_quiet ? 0 : $urandom_range(0, 9);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               cur_op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {cur_op.value, cur_op.key};
               req_tuser <= cur_op.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int  recv_stall = 0;
   int  recv_count = 0;
   bit  recv_quiet = 0;
   always @(posedge clock) begin
      heap_result_type e;
      if (!reset) begin
         if ($urandom_range(0, 299) == 0) recv_quiet = !recv_quiet;
         if (rsp_tvalid && rsp_tready) begin
            recv_count++;
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction %h", rsp_tdata);
               failures++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_tdata[31:0] !== e.key) begin
                  $error("out_key expected %h actual %h", e.key, rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[47:32] !== e.value) begin
                  $error("out_value expected %h actual %h", e.value, rsp_tdata[47:32]);
                  failures++;
               end
               if (rsp_tdata[48] !== e.valid) begin
                  $error("out_valid expected %b actual %b", e.valid, rsp_tdata[48]);
                  failures++;
               end
               if (rsp_tdata[49] !== e.dropped) begin
                  $error("push_dropped expected %b actual %b", e.dropped, rsp_tdata[49]);
                  failures++;
               end
               if (rsp_tdata[50] !== e.empty) begin
                  $error("is_empty expected %b actual %b", e.empty, rsp_tdata[50]);
                  failures++;
               end
               if (rsp_tdata[61:51] !== e.count) begin
                  $error("entry_count expected %0d actual %0d", e.count, rsp_tdata[61:51]);
                  failures++;
               end
            end
            // long hold-off so the block backs up onto its input
            recv_stall = (recv_count == 100) ? 400 :
                         (recv_quiet ? 0 : $urandom_range(0, 9));
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void add_op(logic cmd, logic [31:0] k, logic [15:0] v);
      heap_op_type op;
      op.cmd = cmd;
      op.key = k;
      op.value = v;
      pending_ops = {pending_ops, op};
   endfunction

   function automatic logic [31:0] random_key(logic [31:0] prev);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return prev;
         2: return prev + $urandom_range(0, 300);
         3: return $urandom_range(0, 63);
         default: return {8'($urandom_range(0, 255)), 24'h0} | $urandom_range(0, 4095);
      endcase
   endfunction

   initial begin
      logic [31:0] k;
      for (int i = 0; i < SLOTS; i++) begin
         p_next[i] = i + 1;
         p_prev[i] = 0;
         p_key[i] = '0;
         p_value[i] = '0;
      end
      for (int b = 0; b < BUCKETS; b++) begin
         p_head[b] = NIL;
         p_tail[b] = NIL;
      end
      p_free = 0;
      p_last = '0;
      p_held = 0;

      // directed: empty pop, extremes, key below last popped, equal keys
      add_op(CMD_POP, 32'hFFFFFFFF, 16'hFFFF);
      add_op(CMD_PUSH, 32'h0, 16'h0);
      add_op(CMD_PUSH, 32'hFFFFFFFF, 16'hFFFF);
      add_op(CMD_PUSH, 32'h0, 16'h1234);
      add_op(CMD_POP, 32'h0, 16'h0);
      add_op(CMD_POP, 32'h0, 16'h0);
      add_op(CMD_POP, 32'h0, 16'h0);
      add_op(CMD_POP, 32'h0, 16'h0);
      add_op(CMD_PUSH, 32'd100, 16'hAAAA);
      add_op(CMD_PUSH, 32'd300, 16'h5555);
      add_op(CMD_PUSH, 32'd200, 16'h0F0F);
      add_op(CMD_POP, 32'h0, 16'h0);
      add_op(CMD_PUSH, 32'd5, 16'h00FF);
      add_op(CMD_PUSH, 32'h80000000, 16'h8000);
      add_op(CMD_PUSH, 32'd100, 16'h7FFF);
      for (int i = 0; i < 6; i++) add_op(CMD_POP, 32'h0, 16'h0);

      // random mix
      k = '0;
      for (int i = 0; i < 600; i++) begin
         if ($urandom_range(0, 99) < 58) begin
            k = random_key(k);
            add_op(CMD_PUSH, k, 16'($urandom_range(0, 65535)));
         end else begin
            add_op(CMD_POP, $urandom, 16'($urandom_range(0, 65535)));
         end
      end
      // drain
      for (int i = 0; i < 80; i++) add_op(CMD_POP, 32'h0, 16'h0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (pending_ops.size() == 0 && !req_tvalid && expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rhpq_pkg.sv
hdl/rhpq_ram.sv
hdl/rhpq_ctrl.sv
hdl/rhpq_dp.sv
hdl/radix_heap_priority_queue_top.sv
tb/tb.sv
